>>> rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master package
// Shared command codes, bus symbol codes, control byte constants and the
// transaction kind encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

	// Command codes carried with each input item.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Bus symbol codes carried with each result item.
	typedef enum logic [1:0] {
		SYM_START  = 2'd0,
		SYM_DRIVE  = 2'd1,
		SYM_SAMPLE = 2'd2,
		SYM_STOP   = 2'd3
	} sym_t;

	// Transaction kind, one-hot.
	typedef enum logic [2:0] {
		KIND_IDLE  = 3'b001,
		KIND_WRITE = 3'b010,
		KIND_READ  = 3'b100
	} kind_t;

	localparam logic [7:0] CTRL_WRITE = 8'hA0;
	localparam logic [7:0] CTRL_READ  = 8'hA1;

	// Symbol positions within a transaction.
	localparam logic [5:0] POS_ACK_CTRL  = 6'd9;
	localparam logic [5:0] POS_ACK_ADDR  = 6'd18;
	localparam logic [5:0] POS_WR_ACK    = 6'd27;
	localparam logic [5:0] POS_RD_RSTART = 6'd19;
	localparam logic [5:0] POS_RD_ACK    = 6'd28;
	localparam logic [5:0] POS_RD_NACK   = 6'd37;

	// Control byte with the block select placed in bits three to one.
	function automatic logic [7:0] ctrl_byte(input logic [7:0] base, input logic [2:0] blk);
		ctrl_byte = base | {4'b0000, blk, 1'b0};
	endfunction

endpackage

`default_nettype wire

>>> rtl/i2c_eeprom_byte_master_core.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master core
// Sequences one-byte EEPROM writes and reads as a stream of bus symbols.
// ----------------------------------------------------------------------------
// Usage:
//   The slave-side stream takes one item per command: a start command (write
//   or read) latches the byte address and data byte and returns a START
//   symbol; every bus tick item returns the next bus symbol of the running
//   transaction and carries the SDA level sampled during that tick. Ticks
//   while idle, start commands while busy and the unused command code give
//   no result item.
//   The master-side stream returns one item per symbol; tlast marks the final
//   STOP, which carries the status and, for a read, the received byte.
//   The cfg channel writes the EEPROM block select; it is always ready.
//   A result appears in the cycle after its item is accepted, from a single
//   output register. Throughput is one item per cycle, set by the one output
//   register; while the receiver stalls and that register is full, s_tready
//   is low and no item is taken.
//   Reset clears the transaction state, the block select and the output valid
//   flag; the block comes out of reset idle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_byte_master_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write: block select.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,
	// tdata: byte_address [7:0], write_byte [15:8], sda_sample [16], zero fill.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,
	// tuser: operation [1:0].
	input  wire logic [1:0]  s_tuser,
	// tdata: sda_level [0], status [1], read_byte [9:2], zero fill.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,
	// tuser: symbol [1:0].
	output logic [1:0]       m_tuser,
	// tlast: done_res.
	output logic             m_tlast
);
	import i2cee_pkg::*;

	// Input item fields.
	logic [1:0] in_op;
	logic [7:0] in_addr;
	logic [7:0] in_data;
	logic       in_sda;
	logic       accept;

	// Transaction state.
	logic [2:0] blk_q;
	kind_t      kind_q, kind_n;
	logic [5:0] pos_q, pos_n;
	logic [7:0] shift_q, shift_n;
	logic [7:0] addr_q, addr_n;
	logic [7:0] data_q, data_n;
	logic       nack_q, nack_n;
	logic [7:0] rcv_q, rcv_n;

	// Result of the item being accepted.
	logic       res_valid;
	sym_t       res_sym;
	logic       res_lvl;
	logic       res_done;
	logic       res_st;
	logic [7:0] res_rb;

	// Output register.
	logic       out_valid_q;
	logic [1:0] out_sym_q;
	logic       out_lvl_q;
	logic       out_done_q;
	logic       out_st_q;
	logic [7:0] out_rb_q;

	assign in_op   = s_tuser;
	assign in_addr = s_tdata[7:0];
	assign in_data = s_tdata[15:8];
	assign in_sda  = s_tdata[16];

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Next state and result for one item.
	always_comb begin
		kind_n    = kind_q;
		pos_n     = pos_q;
		shift_n   = shift_q;
		addr_n    = addr_q;
		data_n    = data_q;
		nack_n    = nack_q;
		rcv_n     = rcv_q;
		res_valid = 1'b0;
		res_sym   = SYM_STOP;
		res_lvl   = 1'b1;
		res_done  = 1'b0;
		res_st    = 1'b0;
		res_rb    = 8'd0;
		if (accept) begin
			if (in_op == OP_WRITE || in_op == OP_READ) begin
				if (kind_q == KIND_IDLE) begin
					kind_n    = (in_op == OP_WRITE) ? KIND_WRITE : KIND_READ;
					addr_n    = in_addr;
					data_n    = in_data;
					shift_n   = ctrl_byte(CTRL_WRITE, blk_q);
					nack_n    = 1'b0;
					rcv_n     = 8'd0;
					pos_n     = 6'd1;
					res_valid = 1'b1;
					res_sym   = SYM_START;
				end
			end else if (in_op == OP_TICK && kind_q != KIND_IDLE) begin
				res_valid = 1'b1;
				if (nack_q) begin
					// The slave refused a byte: stop with failure status.
					res_done = 1'b1;
					res_st   = 1'b1;
					res_rb   = (kind_q == KIND_READ) ? rcv_q : 8'd0;
					kind_n   = KIND_IDLE;
					pos_n    = 6'd0;
				end else begin
					pos_n = pos_q + 6'd1;
					case (pos_q) inside
						[6'd1:6'd8], [6'd10:6'd17]: begin
							res_sym = SYM_DRIVE;
							res_lvl = shift_q[7];
							shift_n = {shift_q[6:0], 1'b0};
						end
						POS_ACK_CTRL: begin
							res_sym = SYM_SAMPLE;
							nack_n  = nack_q | in_sda;
							shift_n = addr_q;
						end
						POS_ACK_ADDR: begin
							res_sym = SYM_SAMPLE;
							nack_n  = nack_q | in_sda;
							shift_n = (kind_q == KIND_WRITE) ? data_q : 8'd0;
						end
						default: begin
							if (kind_q == KIND_WRITE) begin
								// Data byte, its acknowledge, then STOP.
								if (pos_q >= 6'd19 && pos_q <= 6'd26) begin
									res_sym = SYM_DRIVE;
									res_lvl = shift_q[7];
									shift_n = {shift_q[6:0], 1'b0};
								end else if (pos_q == POS_WR_ACK) begin
									res_sym = SYM_SAMPLE;
									nack_n  = nack_q | in_sda;
									shift_n = 8'd0;
								end else begin
									res_done = 1'b1;
									kind_n   = KIND_IDLE;
									pos_n    = 6'd0;
								end
							end else begin
								// Repeated START, read control byte, data in, NACK, STOP.
								if (pos_q == POS_RD_RSTART) begin
									res_sym = SYM_START;
									shift_n = ctrl_byte(CTRL_READ, blk_q);
								end else if (pos_q >= 6'd20 && pos_q <= 6'd27) begin
									res_sym = SYM_DRIVE;
									res_lvl = shift_q[7];
									shift_n = {shift_q[6:0], 1'b0};
								end else if (pos_q == POS_RD_ACK) begin
									res_sym = SYM_SAMPLE;
									nack_n  = nack_q | in_sda;
									shift_n = 8'd0;
								end else if (pos_q >= 6'd29 && pos_q <= 6'd36) begin
									res_sym = SYM_SAMPLE;
									rcv_n   = {rcv_q[6:0], in_sda};
								end else if (pos_q == POS_RD_NACK) begin
									res_sym = SYM_DRIVE;
								end else begin
									res_done = 1'b1;
									res_rb   = rcv_q;
									kind_n   = KIND_IDLE;
									pos_n    = 6'd0;
								end
							end
						end
					endcase
				end
			end
		end
	end

	// Control state and block select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q       <= 3'd0;
			kind_q      <= KIND_IDLE;
			pos_q       <= 6'd0;
			shift_q     <= 8'd0;
			addr_q      <= 8'd0;
			data_q      <= 8'd0;
			nack_q      <= 1'b0;
			rcv_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				blk_q <= cfg_data;
			end
			kind_q  <= kind_n;
			pos_q   <= pos_n;
			shift_q <= shift_n;
			addr_q  <= addr_n;
			data_q  <= data_n;
			nack_q  <= nack_n;
			rcv_q   <= rcv_n;
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register, loaded with each new result.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_sym_q  <= res_sym;
			out_lvl_q  <= res_lvl;
			out_done_q <= res_done;
			out_st_q   <= res_st;
			out_rb_q   <= res_rb;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_sym_q;
	assign m_tlast  = out_done_q;
	assign m_tdata  = {6'd0, out_rb_q, out_st_q, out_lvl_q};

endmodule

`default_nettype wire
